>>> src/afelu_pkg.sv
`timescale 1ns / 1ps
package afelu_pkg;

  localparam int unsigned NumEnv  = 3;
  localparam int unsigned NumLen  = 4;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 8;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned CountW  = 8;
  localparam int unsigned StepW   = 3;

  localparam logic [AddrW-1:0] RegPulseOneCtl = 5'h00;
  localparam logic [AddrW-1:0] RegPulseTwoCtl = 5'h04;
  localparam logic [AddrW-1:0] RegTriangleCtl = 5'h08;
  localparam logic [AddrW-1:0] RegNoiseCtl    = 5'h0C;
  localparam logic [AddrW-1:0] RegStatus      = 5'h15;
  localparam logic [AddrW-1:0] RegFrameCtl    = 5'h17;

  localparam logic [LevelW-1:0] LevelMax = 4'd15;

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdTick  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic restart;
    logic clock;
  } env_ctl_t;

  typedef struct packed {
    logic quarter;
    logic half;
  } frame_pulse_t;

  function automatic logic [CountW-1:0] len_lookup(input logic [4:0] idx);
    logic [CountW-1:0] val;
    case (idx)
      5'd0:    val = 8'd10;
      5'd1:    val = 8'd254;
      5'd2:    val = 8'd20;
      5'd3:    val = 8'd2;
      5'd4:    val = 8'd40;
      5'd5:    val = 8'd4;
      5'd6:    val = 8'd80;
      5'd7:    val = 8'd6;
      5'd8:    val = 8'd160;
      5'd9:    val = 8'd8;
      5'd10:   val = 8'd60;
      5'd11:   val = 8'd10;
      5'd12:   val = 8'd14;
      5'd13:   val = 8'd12;
      5'd14:   val = 8'd26;
      5'd15:   val = 8'd14;
      5'd16:   val = 8'd12;
      5'd17:   val = 8'd16;
      5'd18:   val = 8'd24;
      5'd19:   val = 8'd18;
      5'd20:   val = 8'd48;
      5'd21:   val = 8'd20;
      5'd22:   val = 8'd96;
      5'd23:   val = 8'd22;
      5'd24:   val = 8'd192;
      5'd25:   val = 8'd24;
      5'd26:   val = 8'd72;
      5'd27:   val = 8'd26;
      5'd28:   val = 8'd16;
      5'd29:   val = 8'd28;
      5'd30:   val = 8'd32;
      5'd31:   val = 8'd30;
      default: val = 8'd10;
    endcase
    return val;
  endfunction

  function automatic frame_pulse_t seq4_lookup(input logic [1:0] step);
    frame_pulse_t p;
    p.quarter = 1'b1;
    p.half    = step[0];
    return p;
  endfunction

  // steps 0 and 2 carry both pulses, 1 and 3 quarter only, 4 nothing
  function automatic frame_pulse_t seq5_lookup(input logic [StepW-1:0] step);
    frame_pulse_t p;
    case (step)
      3'd0, 3'd2: p = '{quarter: 1'b1, half: 1'b1};
      3'd1, 3'd3: p = '{quarter: 1'b1, half: 1'b0};
      default:    p = '{quarter: 1'b0, half: 1'b0};
    endcase
    return p;
  endfunction

endpackage

>>> src/afelu_if.sv
`timescale 1ns / 1ps
interface afelu_in_if import afelu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [AddrW-1:0] reg_addr;
  logic [DataW-1:0] write_data;

  modport source (output valid, command, reg_addr, write_data, input ready);
  modport sink   (input valid, command, reg_addr, write_data, output ready);
endinterface

interface afelu_out_if import afelu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] pulse_one_volume;
  logic [LevelW-1:0] pulse_two_volume;
  logic              triangle_active;
  logic [LevelW-1:0] noise_volume;
  logic [NumLen-1:0] length_nonzero;

  modport source (output valid, pulse_one_volume, pulse_two_volume, triangle_active,
                  noise_volume, length_nonzero, input ready);
  modport sink   (input valid, pulse_one_volume, pulse_two_volume, triangle_active,
                  noise_volume, length_nonzero, output ready);
endinterface

>>> src/afelu_seq.sv
`timescale 1ns / 1ps
module afelu_seq import afelu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         tick_i,
  input  logic         clear_i,
  input  logic         mode5_i,
  output frame_pulse_t pulse_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] step5;
  frame_pulse_t     pulse;

  always_comb begin
    // a stale step beyond the 5-step range saturates to the idle step
    step5 = (step_q > 3'd4) ? 3'd4 : step_q;
    if (mode5_i) begin
      pulse = seq5_lookup(step5);
    end else begin
      pulse = seq4_lookup(step_q[1:0]);
    end
    step_d = step_q;
    if (clear_i) begin
      step_d = '0;
    end else if (tick_i) begin
      if (mode5_i) begin
        step_d = (step5 == 3'd4) ? 3'd0 : step5 + 3'd1;
      end else begin
        step_d = {1'b0, step_q[1:0] + 2'd1};
      end
    end
    pulse_o.quarter = tick_i & pulse.quarter;
    pulse_o.half    = tick_i & pulse.half;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> src/afelu_env.sv
`timescale 1ns / 1ps
module afelu_env import afelu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  env_ctl_t          ctl_i,
  input  logic [LevelW-1:0] period_i,
  input  logic              loop_i,
  output logic [LevelW-1:0] level_next_o
);

  logic [LevelW-1:0] level_q, level_d;
  logic [LevelW-1:0] div_q, div_d;
  logic              restart_q, restart_d;

  always_comb begin
    level_d   = level_q;
    div_d     = div_q;
    restart_d = restart_q;
    if (ctl_i.restart) begin
      restart_d = 1'b1;
    end else if (ctl_i.clock) begin
      if (restart_q) begin
        restart_d = 1'b0;
        level_d   = LevelMax;
        div_d     = period_i;
      end else if (div_q == '0) begin
        div_d = period_i;
        if (level_q != '0) begin
          level_d = level_q - 4'd1;
        end else if (loop_i) begin
          level_d = LevelMax;
        end
      end else begin
        div_d = div_q - 4'd1;
      end
    end
  end

  assign level_next_o = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      div_q     <= '0;
      restart_q <= 1'b0;
    end else begin
      level_q   <= level_d;
      div_q     <= div_d;
      restart_q <= restart_d;
    end
  end

endmodule

>>> src/afelu_len.sv
`timescale 1ns / 1ps
module afelu_len import afelu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [4:0]        load_idx_i,
  input  logic              dec_i,
  input  logic              halt_i,
  output logic [CountW-1:0] count_next_o
);

  logic [CountW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (load_i) begin
      count_d = len_lookup(load_idx_i);
    end else if (dec_i && !halt_i && count_q != '0) begin
      count_d = count_q - 8'd1;
    end
  end

  assign count_next_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

>>> src/apu_frame_envelope_length_unit.sv
`timescale 1ns / 1ps
// Envelope, length-counter and frame-sequencer control for two pulse voices, a
// triangle voice and a noise voice. Each input beat is a register write or a
// frame tick; each one yields exactly one output beat with the gated levels
// after the update. Throughput is one beat per cycle while the output is not
// stalled: the beat is captured in an input register, the state update and
// output gating run in one combinational pass, and the result lands in an
// output register. A stalled output holds the pipeline; the input register
// still takes a beat whenever it is empty or the output register can advance.
module apu_frame_envelope_length_unit import afelu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  afelu_in_if.sink    in_i,
  afelu_out_if.source out_o
);

  logic             in_valid_q;
  logic             cmd_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] data_q;
  logic             advance, fire, is_tick, is_write;

  logic [DataW-1:0] ctl_p1_q, ctl_p1_d;
  logic [DataW-1:0] ctl_p2_q, ctl_p2_d;
  logic [DataW-1:0] ctl_nz_q, ctl_nz_d;
  logic             tri_halt_q, tri_halt_d;
  logic [3:0]       enable_q, enable_d;
  logic             mode5_q, mode5_d;

  logic [NumLen-1:0] len_load;
  logic [NumLen-1:0] len_halt;
  logic [NumEnv-1:0] env_restart;
  env_ctl_t          env_ctl [NumEnv];
  frame_pulse_t      frame_pulse;
  logic [LevelW-1:0] env_level [NumEnv];
  logic [CountW-1:0] len_count [NumLen];
  logic [NumLen-1:0] nz;

  logic              out_valid_q;
  logic [LevelW-1:0] p1_vol_q, p1_vol_d;
  logic [LevelW-1:0] p2_vol_q, p2_vol_d;
  logic              tri_act_q, tri_act_d;
  logic [LevelW-1:0] nz_vol_q, nz_vol_d;
  logic [NumLen-1:0] nz_q;

  assign advance  = !out_valid_q || out_o.ready;
  assign fire     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;
  assign is_tick  = fire && (cmd_q == CmdTick);
  assign is_write = fire && (cmd_q == CmdWrite);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.command;
      addr_q <= in_i.reg_addr;
      data_q <= in_i.write_data;
    end
  end

  // Only the bytes that steer envelopes, lengths and gating are kept
  always_comb begin
    ctl_p1_d   = ctl_p1_q;
    ctl_p2_d   = ctl_p2_q;
    ctl_nz_d   = ctl_nz_q;
    tri_halt_d = tri_halt_q;
    enable_d   = enable_q;
    mode5_d    = mode5_q;
    if (is_write) begin
      if (addr_q == RegPulseOneCtl) ctl_p1_d = data_q;
      if (addr_q == RegPulseTwoCtl) ctl_p2_d = data_q;
      if (addr_q == RegNoiseCtl)    ctl_nz_d = data_q;
      if (addr_q == RegTriangleCtl) tri_halt_d = data_q[7];
      if (addr_q == RegStatus)      enable_d = data_q[3:0];
      if (addr_q == RegFrameCtl)    mode5_d = data_q[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_p1_q   <= '0;
      ctl_p2_q   <= '0;
      ctl_nz_q   <= '0;
      tri_halt_q <= 1'b0;
      enable_q   <= '0;
      mode5_q    <= 1'b0;
    end else begin
      ctl_p1_q   <= ctl_p1_d;
      ctl_p2_q   <= ctl_p2_d;
      ctl_nz_q   <= ctl_nz_d;
      tri_halt_q <= tri_halt_d;
      enable_q   <= enable_d;
      mode5_q    <= mode5_d;
    end
  end

  afelu_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (is_tick),
    .clear_i (is_write && (addr_q == RegFrameCtl)),
    .mode5_i (mode5_q),
    .pulse_o (frame_pulse)
  );

  // Writes to the fourth register of a voice reload its length
  always_comb begin
    for (int v = 0; v < NumLen; v++) begin
      len_load[v] = is_write && (addr_q[AddrW-1] == 1'b0) && (addr_q[1:0] == 2'b11)
                    && (addr_q[3:2] == 2'(v));
    end
    env_restart = {len_load[3], len_load[1], len_load[0]};
    len_halt    = {ctl_nz_q[5], tri_halt_q, ctl_p2_q[5], ctl_p1_q[5]};
    for (int e = 0; e < NumEnv; e++) begin
      env_ctl[e].restart = env_restart[e];
      env_ctl[e].clock   = frame_pulse.quarter;
    end
  end

  afelu_env u_env_p1 (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (env_ctl[0]),
    .period_i     (ctl_p1_q[3:0]),
    .loop_i       (ctl_p1_q[5]),
    .level_next_o (env_level[0])
  );

  afelu_env u_env_p2 (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (env_ctl[1]),
    .period_i     (ctl_p2_q[3:0]),
    .loop_i       (ctl_p2_q[5]),
    .level_next_o (env_level[1])
  );

  afelu_env u_env_nz (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (env_ctl[2]),
    .period_i     (ctl_nz_q[3:0]),
    .loop_i       (ctl_nz_q[5]),
    .level_next_o (env_level[2])
  );

  for (genvar v = 0; v < NumLen; v++) begin : g_len
    afelu_len u_len (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (len_load[v]),
      .load_idx_i   (data_q[7:3]),
      .dec_i        (frame_pulse.half),
      .halt_i       (len_halt[v]),
      .count_next_o (len_count[v])
    );
    assign nz[v] = (len_count[v] != '0);
  end

  // Gate each voice from the post-update state
  always_comb begin
    p1_vol_d  = '0;
    p2_vol_d  = '0;
    nz_vol_d  = '0;
    if (enable_d[0] && nz[0]) p1_vol_d = ctl_p1_d[4] ? ctl_p1_d[3:0] : env_level[0];
    if (enable_d[1] && nz[1]) p2_vol_d = ctl_p2_d[4] ? ctl_p2_d[3:0] : env_level[1];
    if (enable_d[3] && nz[3]) nz_vol_d = ctl_nz_d[4] ? ctl_nz_d[3:0] : env_level[2];
    tri_act_d = enable_d[2] && nz[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      p1_vol_q  <= p1_vol_d;
      p2_vol_q  <= p2_vol_d;
      tri_act_q <= tri_act_d;
      nz_vol_q  <= nz_vol_d;
      nz_q      <= nz;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.pulse_one_volume = p1_vol_q;
  assign out_o.pulse_two_volume = p2_vol_q;
  assign out_o.triangle_active  = tri_act_q;
  assign out_o.noise_volume     = nz_vol_q;
  assign out_o.length_nonzero   = nz_q;

`ifndef SYNTHESIS
  a_out_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire))
    else $error("output beat appeared without an item leaving the input register");

  a_len_load_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (len_load != '0)) |=> ((nz_q & $past(len_load)) == $past(len_load)))
    else $error("length reload left a zero count");

  a_tri_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && tri_act_q) |-> nz_q[2])
    else $error("triangle active with zero length");

  a_vol_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((p1_vol_q == '0 || nz_q[0]) && (p2_vol_q == '0 || nz_q[1])
                     && (nz_vol_q == '0 || nz_q[3])))
    else $error("voice level nonzero with zero length");
`endif

endmodule

>>> verif/apu_frame_envelope_length_unit_test.sv
`timescale 1ns / 1ps
module apu_frame_envelope_length_unit_test import afelu_pkg::*; ();

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomBeats  = 650;
  localparam int unsigned NumRegs      = 24;
  localparam int unsigned VoiceTri     = 2;
  localparam int unsigned VoiceNoise   = 3;
  localparam int unsigned EnvNoise     = 2;

  localparam logic [CountW-1:0] LengthLoad [32] = '{
    8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
    8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };
  localparam logic [AddrW-1:0] EnvCtlAddr [NumEnv] = '{RegPulseOneCtl, RegPulseTwoCtl,
                                                       RegNoiseCtl};
  localparam logic [AddrW-1:0] LenCtlAddr [NumLen] = '{RegPulseOneCtl, RegPulseTwoCtl,
                                                       RegTriangleCtl, RegNoiseCtl};
  // 5-step sequence: bit s tells whether step s carries that pulse
  localparam logic [4:0] Seq5Quarter = 5'b01111;
  localparam logic [4:0] Seq5Half    = 5'b00101;

  typedef struct packed {
    cmd_e             command;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic             drain_first;
  } apu_beat_t;

  typedef struct packed {
    logic [LevelW-1:0] pulse_one;
    logic [LevelW-1:0] pulse_two;
    logic              triangle;
    logic [LevelW-1:0] noise;
    logic [NumLen-1:0] nonzero;
  } voice_levels_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  afelu_in_if  beat_in ();
  afelu_out_if levels_out ();

  apu_frame_envelope_length_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (beat_in),
    .out_o  (levels_out)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the unit's state
  logic [DataW-1:0]  apu_regs   [NumRegs] = '{default: '0};
  logic [LevelW-1:0] env_level  [NumEnv]  = '{default: '0};
  logic [LevelW-1:0] env_div    [NumEnv]  = '{default: '0};
  logic              env_restart[NumEnv]  = '{default: '0};
  logic [CountW-1:0] len_count  [NumLen]  = '{default: '0};
  logic [StepW-1:0]  frame_step = '0;

  apu_beat_t     pending_beats[$];
  voice_levels_t expected_levels[$];
  int unsigned   mismatches  = 0;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left  = 0;
  int unsigned   gap_left    = 0;
  int unsigned   stall_mode  = 0;
  int unsigned   stall_left  = 0;

  function automatic void clock_envelope(input int unsigned e);
    logic [DataW-1:0] ctl;
    ctl = apu_regs[EnvCtlAddr[e]];
    if (env_restart[e]) begin
      env_restart[e] = 1'b0;
      env_level[e]   = LevelMax;
      env_div[e]     = ctl[3:0];
    end else if (env_div[e] == '0) begin
      env_div[e] = ctl[3:0];
      if (env_level[e] != '0) env_level[e] = env_level[e] - 1'b1;
      else if (ctl[5]) env_level[e] = LevelMax;
    end else begin
      env_div[e] = env_div[e] - 1'b1;
    end
  endfunction

  function automatic logic [LevelW-1:0] gated_level(input int unsigned e, input int unsigned v);
    logic [DataW-1:0] ctl;
    ctl = apu_regs[EnvCtlAddr[e]];
    if (!apu_regs[RegStatus][v] || len_count[v] == '0) return '0;
    return ctl[4] ? ctl[3:0] : env_level[e];
  endfunction

  function automatic voice_levels_t advance_apu(input cmd_e cmd, input logic [AddrW-1:0] addr,
                                                input logic [DataW-1:0] data);
    frame_pulse_t  fp;
    voice_levels_t lv;
    int unsigned   s;
    int unsigned   v;
    if (cmd == CmdTick) begin
      if (apu_regs[RegFrameCtl][7]) begin
        s          = (frame_step > 3'd4) ? 4 : frame_step;
        fp.quarter = Seq5Quarter[s];
        fp.half    = Seq5Half[s];
        frame_step = (s == 4) ? '0 : StepW'(s + 1);
      end else begin
        s          = frame_step[1:0];
        fp.quarter = 1'b1;
        fp.half    = s[0];
        frame_step = StepW'((s + 1) % 4);
      end
      if (fp.quarter)
        for (int e = 0; e < NumEnv; e++) clock_envelope(e);
      if (fp.half)
        for (int i = 0; i < NumLen; i++) begin
          if (len_count[i] != '0 && !((i == VoiceTri) ? apu_regs[RegTriangleCtl][7]
                                                      : apu_regs[LenCtlAddr[i]][5]))
            len_count[i] = len_count[i] - 1'b1;
        end
    end else if (addr < NumRegs) begin
      apu_regs[addr] = data;
      if (addr[1:0] == 2'b11 && addr < 5'h10) begin
        v            = addr[3:2];
        len_count[v] = LengthLoad[data[7:3]];
        if (v == VoiceNoise) env_restart[EnvNoise] = 1'b1;
        else if (v != VoiceTri) env_restart[v] = 1'b1;
      end
      if (addr == RegFrameCtl) frame_step = '0;
    end
    lv.pulse_one = gated_level(0, 0);
    lv.pulse_two = gated_level(1, 1);
    lv.triangle  = apu_regs[RegStatus][VoiceTri] && len_count[VoiceTri] != '0;
    lv.noise     = gated_level(EnvNoise, VoiceNoise);
    for (int i = 0; i < NumLen; i++) lv.nonzero[i] = (len_count[i] != '0);
    return lv;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void push_beat(input cmd_e cmd, input int unsigned addr,
                                    input int unsigned data, input logic drain = 1'b0);
    apu_beat_t b;
    b.command     = cmd;
    b.addr        = AddrW'(addr);
    b.data        = DataW'(data);
    b.drain_first = drain;
    pending_beats.push_back(b);
  endfunction

  // sender: bursts of beats separated by random gaps
  always @(posedge clk_i) begin
    apu_beat_t nxt;
    if (rst_ni) begin
      if (beat_in.valid && beat_in.ready)
        expected_levels.push_back(advance_apu(cmd_e'(beat_in.command), beat_in.reg_addr,
                                              beat_in.write_data));
      if (!beat_in.valid || beat_in.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          beat_in.valid <= 1'b0;
        end else if (pending_beats.size() == 0 ||
                     (pending_beats[0].drain_first && expected_levels.size() != 0)) begin
          beat_in.valid <= 1'b0;
        end else begin
          nxt = pending_beats.pop_front();
          beat_in.valid      <= 1'b1;
          beat_in.command    <= nxt.command;
          beat_in.reg_addr   <= nxt.addr;
          beat_in.write_data <= nxt.data;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: check each beat, stall in phases of varying shape
  always @(posedge clk_i) begin
    voice_levels_t want;
    if (rst_ni && levels_out.valid && levels_out.ready) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0h/%0h/%0b/%0h/%0h",
                 $time, levels_out.pulse_one_volume, levels_out.pulse_two_volume,
                 levels_out.triangle_active, levels_out.noise_volume,
                 levels_out.length_nonzero);
        mismatches++;
      end else begin
        want = expected_levels.pop_front();
        check_field("pulse_one_volume", want.pulse_one, levels_out.pulse_one_volume);
        check_field("pulse_two_volume", want.pulse_two, levels_out.pulse_two_volume);
        check_field("triangle_active", want.triangle, levels_out.triangle_active);
        check_field("noise_volume", want.noise, levels_out.noise_volume);
        check_field("length_nonzero", want.nonzero, levels_out.length_nonzero);
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       levels_out.ready <= 1'b1;
      1:       levels_out.ready <= 1'($urandom_range(0, 1));
      2:       levels_out.ready <= (stall_left % 4 == 0);
      default: levels_out.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("apu_frame_envelope_length_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned data;
    beat_in.valid      = 1'b0;
    beat_in.command    = CmdWrite;
    beat_in.reg_addr   = '0;
    beat_in.write_data = '0;
    levels_out.ready   = 1'b0;
    rst_ni             = 1'b0;

    // directed: idle tick, voice setup, both sequence modes, ignored and disabled cases
    push_beat(CmdTick, 31, 255);
    push_beat(CmdWrite, RegStatus, 8'hFF);
    push_beat(CmdWrite, RegPulseOneCtl, 8'h1A);
    push_beat(CmdWrite, 5'h03, 8'h08);
    push_beat(CmdWrite, RegPulseTwoCtl, 8'h25);
    push_beat(CmdWrite, 5'h07, 8'hFF);
    push_beat(CmdWrite, RegTriangleCtl, 8'h80);
    push_beat(CmdWrite, 5'h0B, 8'h18);
    push_beat(CmdWrite, RegNoiseCtl, 8'h00);
    push_beat(CmdWrite, 5'h0F, 8'h00);
    push_beat(CmdWrite, RegFrameCtl, 8'h00);
    repeat (5) push_beat(CmdTick, 0, 0);
    push_beat(CmdWrite, RegFrameCtl, 8'h80);
    repeat (6) push_beat(CmdTick, 0, 0);
    push_beat(CmdWrite, 24, 8'hFF);
    push_beat(CmdWrite, 31, 8'hAA);
    push_beat(CmdWrite, RegStatus, 8'h00);
    // hold this one until every earlier result has come back
    push_beat(CmdTick, 0, 0, 1'b1);

    for (int i = 0; i < RandomBeats; i++) begin
      r    = $urandom_range(0, 99);
      data = $urandom_range(0, 255);
      if (r < 45)
        push_beat(CmdTick, $urandom_range(0, 31), data, i == 0 || i == RandomBeats / 2);
      else if (r < 57)
        push_beat(CmdWrite, {2'($urandom_range(0, 3)), 2'b11}, data);
      else if (r < 72)
        push_beat(CmdWrite, LenCtlAddr[$urandom_range(0, 3)], data);
      else if (r < 80)
        push_beat(CmdWrite, RegStatus, $urandom_range(0, 1) ? (data | 8'h0F) : data);
      else if (r < 85)
        push_beat(CmdWrite, RegFrameCtl, data);
      else
        push_beat(CmdWrite, $urandom_range(0, 31), data);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_beats.size() != 0 || beat_in.valid || expected_levels.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("apu_frame_envelope_length_unit_test: PASS");
    end else begin
      $display("apu_frame_envelope_length_unit_test: FAIL");
    end
    $finish;
  end

endmodule
